FILE: design/rau_pkg.sv
package rau_pkg;

  // Width of the shared datapath; holds every exact intermediate value.
  localparam int DATA_W = 64;
  localparam int WIDTH_DEF = 32;

  // Operation codes of the kind field.
  localparam logic [1:0] KIND_ADD = 2'd0;
  localparam logic [1:0] KIND_SUB = 2'd1;
  localparam logic [1:0] KIND_MUL = 2'd2;
  localparam logic [1:0] KIND_DIV = 2'd3;

  // Result status codes.
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_ZERO_DEN = 2'd1;
  localparam logic [1:0] ST_DIV_ZERO = 2'd2;
  localparam logic [1:0] ST_OVERFLOW = 2'd3;

  typedef enum logic [4:0] {
    S_IDLE, S_GA, S_DAN, S_DAD, S_GB, S_DBN, S_DBD, S_FIX,
    S_GD, S_QA, S_QB, S_ML, S_MTA, S_MTB, S_COMB,
    S_MRN, S_MRD, S_GR, S_DRN, S_DRD, S_CHK, S_OUT
  } state_t;

  typedef enum logic {
    UOP_GCD,
    UOP_DIV
  } unit_op_t;

  // Command from the sequencer to the shared gcd / divide unit.
  typedef struct packed {
    logic     start;
    unit_op_t op;
    logic     half;
  } unit_cmd_t;

endpackage

FILE: design/rau_if.sv
interface rau_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [31:0] num_a;
  logic [31:0] den_a;
  logic [31:0] num_b;
  logic [31:0] den_b;

  modport source(output valid, kind, num_a, den_a, num_b, den_b, input ready);
  modport sink(input valid, kind, num_a, den_a, num_b, den_b, output ready);
endinterface

interface rau_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] num_out;
  logic [30:0] den_out;
  logic [1:0]  status;

  modport source(output valid, num_out, den_out, status, input ready);
  modport sink(input valid, num_out, den_out, status, output ready);
endinterface

FILE: design/rau_unit.sv
module rau_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  rau_pkg::unit_cmd_t          cmd,
  input  logic [rau_pkg::DATA_W-1:0]  x,
  input  logic [rau_pkg::DATA_W-1:0]  y,
  output logic                        done,
  output logic [rau_pkg::DATA_W-1:0]  res
);
  import rau_pkg::*;

  localparam int CNT_W = $clog2(DATA_W + 1);
  localparam int SH_W  = $clog2(DATA_W);
  localparam int HALF  = DATA_W / 2;

  logic              busy;
  unit_op_t          op;
  logic [DATA_W-1:0] u;
  logic [DATA_W-1:0] v;
  logic [DATA_W-1:0] rem;
  logic [SH_W-1:0]   k;
  logic [CNT_W-1:0]  cnt;

  logic [DATA_W:0]   trial;
  logic              fits;
  logic [DATA_W-1:0] rem_next;
  logic [DATA_W-1:0] quo_next;

  // One restoring division step; u holds the dividend bits and collects the quotient.
  always_comb begin
    trial    = {rem, u[DATA_W-1]};
    fits     = trial >= {1'b0, v};
    rem_next = fits ? DATA_W'(trial - {1'b0, v}) : trial[DATA_W-1:0];
    quo_next = {u[DATA_W-2:0], fits};
  end

  // Binary gcd or long division, one step per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cmd.start && !busy) begin
        busy <= 1'b1;
        op   <= cmd.op;
        v    <= y;
        k    <= '0;
        rem  <= '0;
        if (cmd.op == UOP_DIV && cmd.half) begin
          u   <= {x[HALF-1:0], {HALF{1'b0}}};
          cnt <= CNT_W'(HALF);
        end else begin
          u   <= x;
          cnt <= CNT_W'(DATA_W);
        end
      end else if (busy) begin
        case (op)
          UOP_GCD: begin
            if (u == '0) begin
              res  <= (v == '0) ? DATA_W'(1) : (v << k);
              busy <= 1'b0;
              done <= 1'b1;
            end else if (v == '0) begin
              res  <= u << k;
              busy <= 1'b0;
              done <= 1'b1;
            end else if (!u[0] && !v[0]) begin
              u <= u >> 1;
              v <= v >> 1;
              k <= k + 1'b1;
            end else if (!u[0]) begin
              u <= u >> 1;
            end else if (!v[0]) begin
              v <= v >> 1;
            end else if (u >= v) begin
              u <= u - v;
            end else begin
              v <= v - u;
            end
          end
          UOP_DIV: begin
            rem <= rem_next;
            u   <= quo_next;
            cnt <= cnt - 1'b1;
            if (cnt == CNT_W'(1)) begin
              res  <= quo_next;
              busy <= 1'b0;
              done <= 1'b1;
            end
          end
          default: begin
            busy <= 1'b0;
          end
        endcase
      end
    end
  end

endmodule

FILE: design/rational_arithmetic_unit_top.sv
// Channel  Dir  Beat fields
// req      in   kind, num_a, den_a, num_b, den_b
// rsp      out  num_out, den_out, status
//
// One item at a time: req is ready only while the block is idle.
// The shared gcd / divide unit sets the time: up to four binary gcd runs
// and up to eight divides (32 quotient bits for the operands, 64 for the result),
// plus the control states of the sequencer.
// A zero denominator or divide by zero is answered on the cycle after the beat.
// A result waits in its output register until rsp takes the beat; reset is
// synchronous and returns the sequencer to idle.
module rational_arithmetic_unit_top #(
  parameter int WIDTH = rau_pkg::WIDTH_DEF
) (
  input logic      clk,
  input logic      rst,
  rau_req_if.sink  req,
  rau_rsp_if.source rsp
);
  import rau_pkg::*;

  localparam logic [DATA_W:0] LIMIT = (DATA_W + 1)'(1) << (WIDTH - 1);

  state_t state, state_next;
  logic   issued, issued_next;

  logic [1:0]        kind;
  logic [31:0]       na, da, nb, db;
  logic              sa, sb;
  logic [DATA_W-1:0] g;
  logic [31:0]       qa, qb;
  logic [DATA_W-1:0] l, ta, tb;
  logic [DATA_W-1:0] rn, rd;
  logic              rneg;
  logic [31:0]       onum;
  logic [30:0]       oden;
  logic [1:0]        ost;

  unit_cmd_t         cmd;
  logic [DATA_W-1:0] ux, uy, ures;
  logic              udone;
  logic [31:0]       mx, my;
  logic [DATA_W-1:0] mp;

  logic [31:0] mag_na, mag_da, mag_nb, mag_db;
  logic        sbe;
  logic [DATA_W-1:0] rd_f;
  logic        neg_f, ovf;

  rau_unit u_unit (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd),
    .x    (ux),
    .y    (uy),
    .done (udone),
    .res  (ures)
  );

  // Magnitudes of the incoming fields.
  always_comb begin
    mag_na = req.num_a[31] ? 32'(-req.num_a) : req.num_a;
    mag_da = req.den_a[31] ? 32'(-req.den_a) : req.den_a;
    mag_nb = req.num_b[31] ? 32'(-req.num_b) : req.num_b;
    mag_db = req.den_b[31] ? 32'(-req.den_b) : req.den_b;
  end

  // Shared multiplier operands.
  always_comb begin
    case (state)
      S_ML:    begin mx = qa; my = db; end
      S_MTA:   begin mx = na; my = qb; end
      S_MTB:   begin mx = nb; my = qa; end
      S_MRN:   begin mx = na; my = nb; end
      S_MRD:   begin mx = da; my = db; end
      default: begin mx = na; my = nb; end
    endcase
    mp = DATA_W'(mx) * DATA_W'(my);
  end

  // Effective sign of the second term and the final zero and range checks.
  always_comb begin
    sbe   = (kind == KIND_SUB) ? !sb : sb;
    rd_f  = (rn == '0) ? DATA_W'(1) : rd;
    neg_f = (rn == '0) ? 1'b0 : rneg;
    ovf   = ({1'b0, rd_f} > LIMIT - 1'b1) ||
            (neg_f ? ({1'b0, rn} > LIMIT) : ({1'b0, rn} > LIMIT - 1'b1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      issued <= 1'b0;
    end else begin
      state  <= state_next;
      issued <= issued_next;
    end
  end

  // Sequencer: next state, unit commands.
  always_comb begin
    state_next  = state;
    issued_next = issued;
    cmd.start   = 1'b0;
    cmd.op      = UOP_GCD;
    cmd.half    = 1'b1;
    ux          = DATA_W'(na);
    uy          = DATA_W'(da);
    case (state)
      S_GA:  begin ux = DATA_W'(na); uy = DATA_W'(da); end
      S_DAN: begin cmd.op = UOP_DIV; ux = DATA_W'(na); uy = g; end
      S_DAD: begin cmd.op = UOP_DIV; ux = DATA_W'(da); uy = g; end
      S_GB:  begin ux = DATA_W'(nb); uy = DATA_W'(db); end
      S_DBN: begin cmd.op = UOP_DIV; ux = DATA_W'(nb); uy = g; end
      S_DBD: begin cmd.op = UOP_DIV; ux = DATA_W'(db); uy = g; end
      S_GD:  begin ux = DATA_W'(da); uy = DATA_W'(db); end
      S_QA:  begin cmd.op = UOP_DIV; ux = DATA_W'(da); uy = g; end
      S_QB:  begin cmd.op = UOP_DIV; ux = DATA_W'(db); uy = g; end
      S_GR:  begin ux = rn; uy = rd; end
      S_DRN: begin cmd.op = UOP_DIV; cmd.half = 1'b0; ux = rn; uy = g; end
      S_DRD: begin cmd.op = UOP_DIV; cmd.half = 1'b0; ux = rd; uy = g; end
      default: begin end
    endcase
    case (state)
      S_IDLE: begin
        if (req.valid) begin
          if (req.den_a == '0 || req.den_b == '0 ||
              (req.kind == KIND_DIV && req.num_b == '0)) begin
            state_next = S_OUT;
          end else begin
            state_next = S_GA;
          end
        end
      end
      S_GA, S_DAN, S_DAD, S_GB, S_DBN, S_DBD, S_GD, S_QA, S_QB, S_GR, S_DRN, S_DRD: begin
        cmd.start   = !issued;
        issued_next = 1'b1;
        if (udone) begin
          issued_next = 1'b0;
          case (state)
            S_GA:    state_next = S_DAN;
            S_DAN:   state_next = S_DAD;
            S_DAD:   state_next = S_GB;
            S_GB:    state_next = S_DBN;
            S_DBN:   state_next = S_DBD;
            S_DBD:   state_next = S_FIX;
            S_GD:    state_next = S_QA;
            S_QA:    state_next = S_QB;
            S_QB:    state_next = S_ML;
            S_GR:    state_next = S_DRN;
            S_DRN:   state_next = S_DRD;
            default: state_next = S_CHK;
          endcase
        end
      end
      S_FIX:   state_next = (kind == KIND_ADD || kind == KIND_SUB) ? S_GD : S_MRN;
      S_ML:    state_next = S_MTA;
      S_MTA:   state_next = S_MTB;
      S_MTB:   state_next = S_COMB;
      S_COMB:  state_next = S_GR;
      S_MRN:   state_next = S_MRD;
      S_MRD:   state_next = S_GR;
      S_CHK:   state_next = S_OUT;
      S_OUT:   if (rsp.ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Datapath registers, loaded as the sequencer steps.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        kind <= req.kind;
        na   <= mag_na;
        da   <= mag_da;
        nb   <= mag_nb;
        db   <= mag_db;
        sa   <= req.num_a[31] ^ req.den_a[31];
        sb   <= req.num_b[31] ^ req.den_b[31];
        onum <= '0;
        oden <= '0;
        if (req.den_a == '0 || req.den_b == '0) begin
          ost <= ST_ZERO_DEN;
        end else if (req.kind == KIND_DIV && req.num_b == '0) begin
          ost <= ST_DIV_ZERO;
        end else begin
          ost <= ST_OK;
        end
      end
      S_GA, S_GB, S_GD, S_GR: if (udone) g <= ures;
      S_DAN: if (udone) na <= ures[31:0];
      S_DAD: if (udone) da <= ures[31:0];
      S_DBN: if (udone) nb <= ures[31:0];
      S_DBD: if (udone) db <= ures[31:0];
      S_QA:  if (udone) qa <= ures[31:0];
      S_QB:  if (udone) qb <= ures[31:0];
      S_DRN: if (udone) rn <= ures;
      S_DRD: if (udone) rd <= ures;
      S_FIX: begin
        // A zero operand becomes 0/1; a divide takes the reciprocal of b.
        if (na == '0) begin
          sa <= 1'b0;
          da <= 32'd1;
        end
        if (kind == KIND_DIV) begin
          nb <= db;
          db <= nb;
        end else if (nb == '0) begin
          sb <= 1'b0;
          db <= 32'd1;
        end
      end
      S_ML:  l  <= mp;
      S_MTA: ta <= mp;
      S_MTB: tb <= mp;
      S_COMB: begin
        rd <= l;
        if (sa == sbe) begin
          rn   <= ta + tb;
          rneg <= sa;
        end else if (ta >= tb) begin
          rn   <= ta - tb;
          rneg <= sa;
        end else begin
          rn   <= tb - ta;
          rneg <= sbe;
        end
      end
      S_MRN: begin
        rn   <= mp;
        rneg <= sa ^ sb;
      end
      S_MRD: rd <= mp;
      S_CHK: begin
        if (ovf) begin
          ost  <= ST_OVERFLOW;
          onum <= '0;
          oden <= '0;
        end else begin
          ost  <= ST_OK;
          onum <= neg_f ? 32'(-rn[31:0]) : rn[31:0];
          oden <= rd_f[30:0];
        end
      end
      default: begin end
    endcase
  end

  assign req.ready   = (state == S_IDLE);
  assign rsp.valid   = (state == S_OUT);
  assign rsp.num_out = onum;
  assign rsp.den_out = oden;
  assign rsp.status  = ost;

  // The block never takes a new beat while a result is offered.
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    !(req.ready && rsp.valid)) else $error("input taken while result pending");

  // A good result always has a nonzero denominator.
  a_den_nonzero: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.status == ST_OK) |-> rsp.den_out != '0)
    else $error("zero denominator on ok result");

  // Error results carry zero fields.
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.status != ST_OK) |-> (rsp.num_out == '0 && rsp.den_out == '0))
    else $error("nonzero fields on error result");

  // An accepted beat leaves the idle state on the next cycle.
  a_leave_idle: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !req.ready) else $error("sequencer did not start");

endmodule
